// ===== rtl/cpg_pkg.sv =====
// Package with the shared types and constants of the circle pixel generator.
package cpg_pkg;

  localparam int RADIUS_BITS = 10;
  localparam int COORD_W = 16;
  localparam int STEP_W = RADIUS_BITS + 1;
  localparam int COLOR_W = 24;
  localparam int DEC_W = 14;
  localparam int DX_W = 12;
  localparam int DY_W = 13;

  localparam logic [COORD_W-1:0] LONG_SIDE_LAST = 16'd319;
  localparam logic [COORD_W-1:0] SHORT_SIDE_LAST = 16'd239;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic REG_ORIENT = 1'b0;
  localparam logic REG_FORMAT = 1'b1;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    ORIENT_LAND = 2'd0,
    ORIENT_LAND_REV = 2'd1,
    ORIENT_PORT = 2'd2,
    ORIENT_PORT_REV = 2'd3
  } orient_t;

  typedef enum logic {
    FMT_RGB565 = 1'b0,
    FMT_RGB666 = 1'b1
  } fmt_t;

  typedef struct packed {
    orient_t orientation;
    fmt_t color_format;
  } cfg_t;

  typedef struct packed {
    logic tick;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [STEP_W-1:0] ux;
    logic [STEP_W-1:0] uy;
    logic [COLOR_W-1:0] color;
    logic done;
  } job_t;

endpackage

// ===== rtl/cpg_if.sv =====
// Handshake interfaces for the command channel and the pixel channel.
interface cpg_cmd_if;
  logic valid;
  logic ready;
  logic kind;
  logic [15:0] center_x;
  logic [15:0] center_y;
  logic [9:0] radius;
  logic [23:0] color;

  modport source(output valid, kind, center_x, center_y, radius, color, input ready);
  modport sink(input valid, kind, center_x, center_y, radius, color, output ready);
endinterface

interface cpg_pix_if;
  logic valid;
  logic ready;
  logic [15:0] h_addr;
  logic [15:0] v_addr;
  logic [15:0] word_first;
  logic [15:0] word_second;
  logic last;
  logic done_res;

  modport source(output valid, h_addr, v_addr, word_first, word_second, last, done_res,
                 input ready);
  modport sink(input valid, h_addr, v_addr, word_first, word_second, last, done_res,
               output ready);
endinterface

// ===== rtl/cpg_front.sv =====
// Command front end: holds the midpoint circle state, queues a job per start and step.
module cpg_front
  import cpg_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  cpg_cmd_if.sink    cmd,
  input  logic       q_ready,
  output logic       push,
  output job_t       push_job
);

  logic [COORD_W-1:0] center_col;
  logic [COORD_W-1:0] center_row;
  logic [COLOR_W-1:0] draw_color;
  logic [STEP_W-1:0] step_x;
  logic [STEP_W-1:0] step_y;
  logic signed [DEC_W-1:0] decision;
  logic [DX_W-1:0] delta_x;
  logic signed [DY_W-1:0] delta_y;
  logic active;

  logic accept;
  logic tick_go;
  logic [STEP_W-1:0] r_ext;
  logic [STEP_W-1:0] x_next;
  logic [STEP_W-1:0] y_next;
  logic [DX_W-1:0] dx_next;
  logic signed [DY_W-1:0] dy_next;
  logic signed [DEC_W-1:0] dec_mid;
  logic signed [DEC_W-1:0] dec_next;
  logic step_done;
  logic start_done;

  assign cmd.ready = q_ready;
  assign accept = cmd.valid && q_ready;
  assign tick_go = active && (step_x < step_y);
  assign r_ext = {1'b0, cmd.radius[RADIUS_BITS-1:0]};
  assign start_done = (cmd.radius[RADIUS_BITS-1:0] == '0);

  always_comb begin
    y_next = step_y;
    dy_next = delta_y;
    dec_mid = decision;
    if (!decision[DEC_W-1]) begin
      y_next = step_y - 1'b1;
      dy_next = delta_y + DY_W'(2);
      dec_mid = decision + {{(DEC_W-DY_W){dy_next[DY_W-1]}}, dy_next};
    end
    x_next = step_x + 1'b1;
    dx_next = delta_x + DX_W'(2);
    dec_next = dec_mid + $signed({{(DEC_W-DX_W){1'b0}}, dx_next}) + DEC_W'(1);
  end

  assign step_done = (x_next >= y_next);

  always_comb begin
    push = 1'b0;
    push_job.tick = KIND_TICK;
    push_job.cx = center_col;
    push_job.cy = center_row;
    push_job.ux = x_next;
    push_job.uy = y_next;
    push_job.color = draw_color;
    push_job.done = step_done;
    if (accept) begin
      if (cmd.kind == KIND_START) begin
        push = 1'b1;
        push_job.tick = KIND_START;
        push_job.cx = cmd.center_x;
        push_job.cy = cmd.center_y;
        push_job.ux = '0;
        push_job.uy = r_ext;
        push_job.color = cmd.color;
        push_job.done = start_done;
      end else begin
        push = tick_go;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      center_col <= '0;
      center_row <= '0;
      draw_color <= '0;
      step_x <= '0;
      step_y <= '0;
      decision <= '0;
      delta_x <= '0;
      delta_y <= '0;
      active <= 1'b0;
    end else if (accept) begin
      if (cmd.kind == KIND_START) begin
        center_col <= cmd.center_x;
        center_row <= cmd.center_y;
        draw_color <= cmd.color;
        step_x <= '0;
        step_y <= r_ext;
        decision <= DEC_W'(1) - $signed({{(DEC_W-STEP_W){1'b0}}, r_ext});
        delta_x <= '0;
        delta_y <= -$signed({{(DY_W-STEP_W-1){1'b0}}, r_ext, 1'b0});
        active <= !start_done;
      end else if (tick_go) begin
        step_x <= x_next;
        step_y <= y_next;
        decision <= dec_next;
        delta_x <= dx_next;
        delta_y <= dy_next;
        active <= !step_done;
      end
    end
  end

`ifndef SYNTHESIS
  a_active_order: assert property (@(posedge clk) disable iff (rst)
    active |-> (step_x < step_y))
    else $error("active circle with x not below y");
`endif

endmodule

// ===== rtl/cpg_queue.sv =====
// Two-entry job queue between the front end and the point generator.
module cpg_queue
  import cpg_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic q_ready,
  input  logic pop,
  output logic head_valid,
  output job_t head
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign q_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && !q_ready))
    else $error("job pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && !head_valid))
    else $error("job popped from an empty queue");
`endif

endmodule

// ===== rtl/cpg_back.sv =====
// Point generator: walks each queued job, maps points to panel addresses and packs the color.
module cpg_back
  import cpg_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       head_valid,
  input  job_t       head,
  output logic       pop,
  cpg_pix_if.source  pix
);

  logic [2:0] cnt;
  logic [2:0] pidx;
  logic load;
  logic last_pt;
  logic out_valid;
  logic [COORD_W-1:0] a_ext;
  logic [COORD_W-1:0] b_ext;
  logic [COORD_W-1:0] px;
  logic [COORD_W-1:0] py;
  logic [COORD_W-1:0] h_next;
  logic [COORD_W-1:0] v_next;
  logic [15:0] w1_next;
  logic [15:0] w2_next;
  logic [COLOR_W-1:0] c;

  assign load = head_valid && (!out_valid || pix.ready);
  assign last_pt = head.tick ? (cnt == 3'd7) : (cnt == 3'd3);
  assign pop = load && last_pt;

  // Start jobs emit the tick points 0, 2, 4 and 5, which are the four axis points.
  assign pidx = head.tick ? cnt : {cnt[1], !cnt[1] && cnt[0], cnt[1] && cnt[0]};

  assign a_ext = pidx[2] ? {{(COORD_W-STEP_W){1'b0}}, head.uy}
                         : {{(COORD_W-STEP_W){1'b0}}, head.ux};
  assign b_ext = pidx[2] ? {{(COORD_W-STEP_W){1'b0}}, head.ux}
                         : {{(COORD_W-STEP_W){1'b0}}, head.uy};
  assign px = pidx[0] ? head.cx - a_ext : head.cx + a_ext;
  assign py = pidx[1] ? head.cy - b_ext : head.cy + b_ext;

  always_comb begin
    case (cfg.orientation)
      ORIENT_LAND: begin
        h_next = py;
        v_next = LONG_SIDE_LAST - px;
      end
      ORIENT_LAND_REV: begin
        h_next = SHORT_SIDE_LAST - py;
        v_next = px;
      end
      ORIENT_PORT: begin
        h_next = px;
        v_next = py;
      end
      default: begin
        h_next = SHORT_SIDE_LAST - px;
        v_next = LONG_SIDE_LAST - py;
      end
    endcase
  end

  assign c = head.color;

  always_comb begin
    case (cfg.color_format)
      FMT_RGB666: begin
        w1_next = {14'd0, c[23:22]};
        w2_next = {c[21:18], c[15:10], c[7:2]};
      end
      default: begin
        w1_next = {c[23:19], c[15:10], c[7:3]};
        w2_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        cnt <= last_pt ? 3'd0 : cnt + 3'd1;
        out_valid <= 1'b1;
      end else if (pix.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pix.h_addr <= h_next;
      pix.v_addr <= v_next;
      pix.word_first <= w1_next;
      pix.word_second <= w2_next;
      pix.last <= last_pt;
      pix.done_res <= head.done;
    end
  end

  assign pix.valid = out_valid;

`ifndef SYNTHESIS
  a_start_count: assert property (@(posedge clk) disable iff (rst)
    (head_valid && (head.tick == KIND_START)) |-> !cnt[2])
    else $error("start job walked past its fourth point");
`endif

endmodule

// ===== rtl/circle_pixel_generator.sv =====
// Top level of the midpoint circle pixel generator.
// A command's first point goes through the job queue and then the output register.
// A start command yields four points and a drawing step eight, one point per cycle from
// the single point generator while pix.ready holds; a step past the end queues no job.
// Commands are taken back to back while a two-entry job queue has room.
// Synchronous reset clears the configuration, the circle state, the queue and the output.
module circle_pixel_generator
  import cpg_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [1:0] cfg_data,
  cpg_cmd_if.sink    cmd,
  cpg_pix_if.source  pix
);

  cfg_t cfg;
  logic push;
  job_t push_job;
  logic q_ready;
  logic pop;
  logic head_valid;
  job_t head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.orientation <= ORIENT_LAND;
      cfg.color_format <= FMT_RGB565;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIENT: cfg.orientation <= orient_t'(cfg_data);
        REG_FORMAT: cfg.color_format <= fmt_t'(cfg_data[0]);
        default: cfg <= cfg;
      endcase
    end
  end

  cpg_front u_front (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .q_ready(q_ready),
    .push(push),
    .push_job(push_job)
  );

  cpg_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_job(push_job),
    .q_ready(q_ready),
    .pop(pop),
    .head_valid(head_valid),
    .head(head)
  );

  cpg_back u_back (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .head_valid(head_valid),
    .head(head),
    .pop(pop),
    .pix(pix)
  );

endmodule
